>>> rtl/core/ocv_pkg.sv
// Shared types, constants and color helper for the occupancy cell colorizer.
package ocv_pkg;

    localparam int CORDIC_STEPS = 15;
    localparam int CW           = 26;  // CORDIC x/y width, covers 2^23 prescaled inputs plus gain
    localparam int DIST_STAGES  = 5;
    localparam logic [15:0] HALF_TURN = 16'd32768;

    typedef logic [0:0] t_cfg_idx;
    localparam t_cfg_idx REG_OCC_THR  = 1'b0;
    localparam t_cfg_idx REG_DIST_THR = 1'b1;

    typedef struct packed {
        logic                 valid;
        logic                 bypass;  // vy == 0, angle is already final
        logic                 occ_ok;
        logic [7:0]           gray;
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic [15:0]          z;
    } t_cstate;

    function automatic logic [15:0] turn_step(input int step);
        logic [15:0] v;
        case (step)
            0:       v = 16'd8192;
            1:       v = 16'd4836;
            2:       v = 16'd2555;
            3:       v = 16'd1297;
            4:       v = 16'd651;
            5:       v = 16'd326;
            6:       v = 16'd163;
            7:       v = 16'd81;
            8:       v = 16'd41;
            9:       v = 16'd20;
            10:      v = 16'd10;
            11:      v = 16'd5;
            12:      v = 16'd3;
            default: v = 16'd1;
        endcase
        return v;
    endfunction

    // Saturated hue to {blue, green, red}.
    function automatic logic [23:0] hue_rgb(input logic [15:0] h);
        logic [18:0] s;
        logic [15:0] f;
        logic [23:0] tp;
        logic [24:0] qp;
        logic [7:0]  t;
        logic [7:0]  q;
        logic [23:0] rgb;
        s  = 19'(h) * 19'd6;
        f  = s[15:0];
        tp = 24'(f) * 24'd255;
        qp = 25'(17'd65536 - 17'(f)) * 25'd255;
        t  = tp[23:16];
        q  = qp[23:16];
        case (s[18:16])
            3'd0:    rgb = {8'd0,   t,     8'd255};
            3'd1:    rgb = {8'd0,   8'd255, q};
            3'd2:    rgb = {t,      8'd255, 8'd0};
            3'd3:    rgb = {8'd255, q,     8'd0};
            3'd4:    rgb = {8'd255, 8'd0,  t};
            default: rgb = {q,      8'd0,  8'd255};
        endcase
        return rgb;
    endfunction

endpackage

>>> rtl/core/ocv_dist.sv
// Pipelined velocity Mahalanobis distance test against the threshold.
module ocv_dist (
    input  logic               i_clk,
    input  logic               i_en,
    input  logic signed [15:0] i_vx,
    input  logic signed [15:0] i_vy,
    input  logic        [15:0] i_cxx,
    input  logic        [15:0] i_cyy,
    input  logic signed [15:0] i_cxy,
    input  logic        [23:0] i_thr,
    output logic               o_dist_ok
);
    import ocv_pkg::*;

    logic signed [31:0] r_vxx, r_vyy, r_vxy, r_cxy2;
    logic        [31:0] r_cc;
    logic        [15:0] r_cxx, r_cyy;
    logic signed [15:0] r_cxy;
    logic signed [47:0] r_a, r_b, r_c;
    logic signed [33:0] r_det;
    logic signed [50:0] r_num, r_num2;
    logic               r_detpos, r_detpos2;
    logic        [31:0] r_detu;
    logic        [55:0] r_prod;
    logic               r_ok;
    logic signed [50:0] n_num;

    assign n_num = 51'(r_a) - (51'(r_b) <<< 1) + 51'(r_c);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_vxx  <= i_vx * i_vx;
            r_vyy  <= i_vy * i_vy;
            r_vxy  <= i_vx * i_vy;
            r_cxy2 <= i_cxy * i_cxy;
            r_cc   <= i_cxx * i_cyy;
            r_cxx  <= i_cxx;
            r_cyy  <= i_cyy;
            r_cxy  <= i_cxy;

            r_a   <= r_vxx * $signed({1'b0, r_cyy});
            r_b   <= r_vxy * r_cxy;
            r_c   <= r_vyy * $signed({1'b0, r_cxx});
            r_det <= $signed({2'b00, r_cc}) - 34'(r_cxy2);

            r_num    <= n_num;
            r_detpos <= (r_det > 34'sd0);
            r_detu   <= r_det[31:0];

            r_num2    <= r_num;
            r_detpos2 <= r_detpos;
            r_prod    <= 56'(i_thr) * 56'(r_detu);

            r_ok <= r_detpos2 && (57'(r_num2) >= $signed({1'b0, r_prod}));
        end
    end

    assign o_dist_ok = r_ok;

endmodule

>>> rtl/core/ocv_cell.sv
// One CORDIC vectoring step of the hue angle chain.
module ocv_cell #(
    parameter int STEP = 0
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  ocv_pkg::t_cstate i_st,
    output ocv_pkg::t_cstate o_st
);
    import ocv_pkg::*;

    localparam logic [15:0] ANG = turn_step(STEP);

    t_cstate r_st, n_st;

    always_comb begin
        n_st = i_st;
        if (!i_st.bypass) begin
            if (i_st.y >= 0) begin
                n_st.x = i_st.x + (i_st.y >>> STEP);
                n_st.y = i_st.y - (i_st.x >>> STEP);
                n_st.z = i_st.z + ANG;
            end else begin
                n_st.x = i_st.x - (i_st.y >>> STEP);
                n_st.y = i_st.y + (i_st.x >>> STEP);
                n_st.z = i_st.z - ANG;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st.valid <= 1'b0;
        end else if (i_en) begin
            r_st.valid <= n_st.valid;
        end
        if (i_en) begin
            r_st.bypass <= n_st.bypass;
            r_st.occ_ok <= n_st.occ_ok;
            r_st.gray   <= n_st.gray;
            r_st.x      <= n_st.x;
            r_st.y      <= n_st.y;
            r_st.z      <= n_st.z;
        end
    end

    assign o_st = r_st;

endmodule

>>> rtl/core/occupancy_cell_velocity_colorizer_core.sv
// Top level of the occupancy grid cell colorizer.
// Usage:
//   Slave stream takes one grid cell per item: free/occupied belief, mean
//   velocity and its covariance. Master stream returns one item per cell:
//   RGB color in tdata and the dynamic flag in tuser.
//   Thresholds are written through the plain config port while idle.
// Throughput and pipeline:
//   One item per cycle, unless the receiver stalls the output (see Stall).
//   Each item passes an input stage, the 15-cell CORDIC chain for the
//   hue angle and the output color register; the distance test runs
//   alongside in a 5-stage multiplier pipeline.
// Reset:
//   Synchronous active-low reset empties the pipeline and loads the
//   thresholds with 1.0 occupancy and 1.0 distance.
// Stall:
//   When the receiver holds tready low with a result waiting, the whole
//   pipeline freezes and s_tready drops; nothing is lost.
module occupancy_cell_velocity_colorizer_core (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic [0:0]   i_cfg_addr,
    input  logic [23:0]  i_cfg_wdata,
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    // free_belief, occupied_belief, velocity_x, velocity_y,
    // variance_x, variance_y, covariance_xy (16 bits each)
    input  logic [111:0] i_s_tdata,
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    // red, green, blue
    output logic [23:0]  o_m_tdata,
    // is_dynamic
    output logic         o_m_tuser
);
    import ocv_pkg::*;

    localparam int DLY = CORDIC_STEPS + 1 - DIST_STAGES;

    logic [16:0] r_occ_thr;
    logic [23:0] r_dist_thr;
    logic        en;

    logic        [15:0] fr, oc, cxx, cyy;
    logic signed [15:0] vx, vy, cxy;
    logic        [16:0] occ_sum;
    logic        [15:0] occ;
    logic        [23:0] gray_prod;

    t_cstate r_s0, n_s0;
    t_cstate chain [0:CORDIC_STEPS];

    logic dist_ok;
    logic r_dly [0:DLY-1];

    logic        r_out_valid;
    logic [23:0] r_rgb;
    logic        r_dyn;
    logic        fin_dyn;

    assign en         = !r_out_valid || i_m_tready;
    assign o_s_tready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ_thr  <= 17'd65536;
            r_dist_thr <= 24'd256;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                REG_OCC_THR:  r_occ_thr  <= i_cfg_wdata[16:0];
                REG_DIST_THR: r_dist_thr <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    assign fr  = i_s_tdata[15:0];
    assign oc  = i_s_tdata[31:16];
    assign vx  = $signed(i_s_tdata[47:32]);
    assign vy  = $signed(i_s_tdata[63:48]);
    assign cxx = i_s_tdata[79:64];
    assign cyy = i_s_tdata[95:80];
    assign cxy = $signed(i_s_tdata[111:96]);

    assign occ_sum   = 17'(oc) + 17'd65536 - 17'(fr);
    assign occ       = occ_sum[16:1];
    assign gray_prod = 24'(occ) * 24'd255;

    always_comb begin
        n_s0.valid  = i_s_tvalid;
        n_s0.bypass = (vy == 16'sd0);
        n_s0.occ_ok = ({1'b0, occ} >= r_occ_thr);
        n_s0.gray   = 8'd255 - gray_prod[23:16];
        // fold the left half plane onto the right one
        if (vx < 0) begin
            n_s0.x = -(CW'(vx) <<< 8);
            n_s0.y = -(CW'(vy) <<< 8);
            n_s0.z = HALF_TURN;
        end else begin
            n_s0.x = CW'(vx) <<< 8;
            n_s0.y = CW'(vy) <<< 8;
            n_s0.z = 16'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0.valid <= 1'b0;
        end else if (en) begin
            r_s0.valid <= n_s0.valid;
        end
        if (en) begin
            r_s0.bypass <= n_s0.bypass;
            r_s0.occ_ok <= n_s0.occ_ok;
            r_s0.gray   <= n_s0.gray;
            r_s0.x      <= n_s0.x;
            r_s0.y      <= n_s0.y;
            r_s0.z      <= n_s0.z;
        end
    end

    assign chain[0] = r_s0;

    for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_cell
        ocv_cell #(.STEP(g)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_st    (chain[g]),
            .o_st    (chain[g+1])
        );
    end

    ocv_dist u_dist (
        .i_clk     (i_clk),
        .i_en      (en),
        .i_vx      (vx),
        .i_vy      (vy),
        .i_cxx     (cxx),
        .i_cyy     (cyy),
        .i_cxy     (cxy),
        .i_thr     (r_dist_thr),
        .o_dist_ok (dist_ok)
    );

    // align the distance verdict with the end of the CORDIC chain
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dly[0] <= dist_ok;
            for (int k = 1; k < DLY; k++) begin
                r_dly[k] <= r_dly[k-1];
            end
        end
    end

    assign fin_dyn = chain[CORDIC_STEPS].occ_ok && r_dly[DLY-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= chain[CORDIC_STEPS].valid;
        end
        if (en) begin
            r_dyn <= fin_dyn;
            if (fin_dyn) begin
                r_rgb <= hue_rgb(chain[CORDIC_STEPS].z);
            end else begin
                r_rgb <= {3{chain[CORDIC_STEPS].gray}};
            end
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_rgb;
    assign o_m_tuser  = r_dyn;

`ifndef SYNTH
    a_ready_rule: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_s_tready == (!o_m_tvalid || i_m_tready))
        else $error("s_tready does not follow output register state");

    a_gray_equal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !o_m_tuser) |->
            (o_m_tdata[7:0] == o_m_tdata[15:8] && o_m_tdata[15:8] == o_m_tdata[23:16]))
        else $error("non-dynamic cell is not gray");

    a_hue_saturated: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser) |->
            (o_m_tdata[7:0] == 8'd255 || o_m_tdata[15:8] == 8'd255 ||
             o_m_tdata[23:16] == 8'd255))
        else $error("hue color lacks a full channel");

    a_hold_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=> ($stable(chain[CORDIC_STEPS]) && $stable(r_s0)))
        else $error("pipeline moved during stall");
`endif

endmodule

>>> dv/ocv_checker.sv
// Checker for the cell colorizer: predicts each cell color and compares results.
`timescale 1ns / 100ps
module ocv_checker (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic [0:0]   i_cfg_addr,
    input  logic [23:0]  i_cfg_wdata,
    input  logic         i_s_tvalid,
    input  logic         i_s_tready,
    input  logic [111:0] i_s_tdata,
    input  logic         i_m_tvalid,
    input  logic         i_m_tready,
    input  logic [23:0]  i_m_tdata,
    input  logic         i_m_tuser,
    output int           o_fail_count,
    output int           o_pending
);
    import ocv_pkg::*;

    typedef struct packed {
        logic       dyn;
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } t_color;

    logic [16:0] occ_thr;
    logic [23:0] dist_thr;
    t_color      color_q[$];

    function automatic longint shr_floor(longint v, int s);
        return v >>> s;
    endfunction

    function automatic logic [15:0] heading_turn(longint vx, longint vy);
        longint x, y, nx;
        int     z;
        int     tbl[15] = '{8192, 4836, 2555, 1297, 651, 326, 163, 81, 41, 20, 10, 5, 3, 1, 1};
        if (vy == 0) return (vx < 0) ? 16'd32768 : 16'd0;
        if (vx < 0) begin
            x = -vx * 256; y = -vy * 256; z = 32768;
        end else begin
            x = vx * 256; y = vy * 256; z = 0;
        end
        for (int i = 0; i < 15; i++) begin
            if (y >= 0) begin
                nx = x + shr_floor(y, i); y = y - shr_floor(x, i); z += tbl[i];
            end else begin
                nx = x - shr_floor(y, i); y = y + shr_floor(x, i); z -= tbl[i];
            end
            x = nx;
        end
        return z[15:0];
    endfunction

    function automatic t_color color_cell(logic [111:0] d);
        longint fr, oc, vx, vy, cxx, cyy, cxy, occ, num, det, s, f, t, q;
        t_color c;
        fr  = d[15:0];
        oc  = d[31:16];
        vx  = longint'($signed(d[47:32]));
        vy  = longint'($signed(d[63:48]));
        cxx = d[79:64];
        cyy = d[95:80];
        cxy = longint'($signed(d[111:96]));
        occ = (oc + 65536 - fr) >>> 1;
        if (occ < 0) occ = 0;
        if (occ > 65536) occ = 65536;
        num = vx * vx * cyy - 2 * vx * vy * cxy + vy * vy * cxx;
        det = cxx * cyy - cxy * cxy;
        c.dyn = (occ >= longint'(occ_thr)) && (det > 0) && (num >= longint'(dist_thr) * det);
        if (c.dyn) begin
            s = longint'(heading_turn(vx, vy)) * 6;
            f = s & 65535;
            t = (f * 255) >> 16;
            q = ((65536 - f) * 255) >> 16;
            case (s >> 16)
                0: begin c.red = 255; c.green = t[7:0]; c.blue = 0; end
                1: begin c.red = q[7:0]; c.green = 255; c.blue = 0; end
                2: begin c.red = 0; c.green = 255; c.blue = t[7:0]; end
                3: begin c.red = 0; c.green = q[7:0]; c.blue = 255; end
                4: begin c.red = t[7:0]; c.green = 0; c.blue = 255; end
                default: begin c.red = 255; c.green = 0; c.blue = q[7:0]; end
            endcase
        end else begin
            c.red   = 8'(255 - ((occ * 255) >> 16));
            c.green = c.red;
            c.blue  = c.red;
        end
        return c;
    endfunction

    assign o_pending = color_q.size();

    always @(posedge i_clk) begin
        t_color want, got;
        if (!i_rst_n) begin
            occ_thr  <= 17'd65536;
            dist_thr <= 24'd256;
            o_fail_count <= 0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_addr == REG_OCC_THR) occ_thr <= i_cfg_wdata[16:0];
                else if (i_cfg_addr == REG_DIST_THR) dist_thr <= i_cfg_wdata;
            end
            if (i_s_tvalid && i_s_tready) color_q.push_back(color_cell(i_s_tdata));
            if (i_m_tvalid && i_m_tready) begin
                got = {i_m_tuser, i_m_tdata[23:16], i_m_tdata[15:8], i_m_tdata[7:0]};
                if (color_q.size() == 0) begin
                    $display("%0t: unexpected result %h", $time, got);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = color_q.pop_front();
                    if (want != got) begin
                        $display("%0t: mismatch expected r%0d g%0d b%0d dyn%0d actual r%0d g%0d b%0d dyn%0d",
                                 $time, want.red, want.green, want.blue, want.dyn,
                                 got.red, got.green, got.blue, got.dyn);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
        end
    end
endmodule

>>> dv/tb.sv
// Testbench top: drives cells and thresholds into the colorizer and gives the verdict.
`timescale 1ns / 100ps
module tb;
    import ocv_pkg::*;

    logic         clk = 0, rst_n = 0;
    logic         cfg_we = 0;
    logic [0:0]   cfg_addr = REG_OCC_THR;
    logic [23:0]  cfg_wdata = 0;
    logic         s_tvalid = 0, s_tready;
    logic [111:0] s_tdata = 0;
    logic         m_tvalid, m_tready = 0;
    logic [23:0]  m_tdata;
    logic         m_tuser;
    int           fail_count, pending;
    int           stall_mode = 0;

    always begin
        #5 clk = 1;
        #5 clk = 0;
    end

    occupancy_cell_velocity_colorizer_core u_dut (
        .i_clk(clk), .i_rst_n(rst_n), .i_cfg_we(cfg_we), .i_cfg_addr(cfg_addr),
        .i_cfg_wdata(cfg_wdata), .i_s_tvalid(s_tvalid), .o_s_tready(s_tready),
        .i_s_tdata(s_tdata), .o_m_tvalid(m_tvalid), .i_m_tready(m_tready),
        .o_m_tdata(m_tdata), .o_m_tuser(m_tuser)
    );

    ocv_checker u_chk (
        .i_clk(clk), .i_rst_n(rst_n), .i_cfg_we(cfg_we), .i_cfg_addr(cfg_addr),
        .i_cfg_wdata(cfg_wdata), .i_s_tvalid(s_tvalid), .i_s_tready(s_tready),
        .i_s_tdata(s_tdata), .i_m_tvalid(m_tvalid), .i_m_tready(m_tready),
        .i_m_tdata(m_tdata), .i_m_tuser(m_tuser), .o_fail_count(fail_count),
        .o_pending(pending)
    );

    // Receiver stalls follow a rotating pattern: none, periodic, random.
    always @(negedge clk) begin
        case (stall_mode)
            0: m_tready <= 1'b1;
            1: m_tready <= ($time / 10) % 5 != 0;
            default: m_tready <= $urandom_range(0, 2) != 0;
        endcase
    end

    initial begin
        #3000000;
        $display("TB_ERROR");
        $finish;
    end

    task automatic write_reg(input logic [0:0] idx, input logic [23:0] val);
        @(negedge clk);
        cfg_we <= 1; cfg_addr <= idx; cfg_wdata <= val;
        @(negedge clk);
        cfg_we <= 0;
    endtask

    // Hold each cell until accepted, with a random gap before a new burst.
    task automatic send_cell(input logic [111:0] d, input bit gap);
        int g;
        g = gap ? $urandom_range(0, 4) : 0;
        if (g > 0) begin
            s_tvalid <= 0;
            repeat (g) @(negedge clk);
        end
        s_tvalid <= 1; s_tdata <= d;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic drain();
        @(negedge clk);
        s_tvalid <= 0;
        while (pending != 0) @(negedge clk);
        repeat (20) @(negedge clk);
    endtask

    function automatic logic [111:0] pack_cell(logic [15:0] fr, logic [15:0] oc,
            logic [15:0] vx, logic [15:0] vy, logic [15:0] cxx, logic [15:0] cyy,
            logic [15:0] cxy);
        return {cxy, cyy, cxx, vy, vx, oc, fr};
    endfunction

    // Mostly cells that can turn dynamic: small covariance, random velocity, high occupancy.
    function automatic logic [111:0] rand_cell();
        logic [15:0] w[7];
        for (int i = 0; i < 7; i++) w[i] = 16'($urandom);
        if ($urandom_range(0, 3) != 0) begin
            w[0] = 16'($urandom_range(0, 4000));
            w[1] = 16'($urandom_range(20000, 65535));
            w[4] = 16'($urandom_range(1, 600));
            w[5] = 16'($urandom_range(1, 600));
            w[6] = 16'($signed($urandom_range(0, 200)) - 100);
            if ($urandom_range(0, 7) == 0) w[3] = 16'd0;
        end
        return pack_cell(w[0], w[1], w[2], w[3], w[4], w[5], w[6]);
    endfunction

    initial begin
        logic [23:0] occ_set[4]  = '{24'd65536, 24'd0, 24'd40000, 24'd131071};
        logic [23:0] dist_set[4] = '{24'd256, 24'd0, 24'd16777215, 24'd5000};
        repeat (2) @(negedge clk);
        rst_n <= 1;
        @(negedge clk);
        // Directed: extremes, axis velocities, bad determinant, both thresholds at zero.
        write_reg(REG_OCC_THR, 24'd0);
        write_reg(REG_DIST_THR, 24'd0);
        send_cell(pack_cell(0, 0, 0, 0, 0, 0, 0), 0);
        send_cell(pack_cell(16'hFFFF, 16'hFFFF, 16'h7FFF, 16'h8000, 16'hFFFF, 16'hFFFF, 16'h7FFF), 0);
        send_cell(pack_cell(0, 16'hFFFF, 16'h0100, 0, 256, 256, 0), 0);
        send_cell(pack_cell(0, 16'hFFFF, 16'hFF00, 0, 256, 256, 0), 0);
        send_cell(pack_cell(0, 16'hFFFF, 0, 16'h0100, 256, 256, 0), 0);
        send_cell(pack_cell(0, 16'hFFFF, 0, 16'hFF00, 256, 256, 0), 0);
        send_cell(pack_cell(0, 16'hFFFF, 16'h8000, 16'h8000, 1, 1, 0), 0);
        send_cell(pack_cell(0, 16'hFFFF, 16'h0100, 16'h0100, 256, 256, 256), 0);
        send_cell(pack_cell(0, 16'hFFFF, 16'h0100, 16'h0100, 100, 100, 16'h8000), 0);
        send_cell(pack_cell(16'hFFFF, 0, 16'h0100, 16'h0300, 1, 1, 0), 0);
        for (int k = 0; k < 12; k++)
            send_cell(pack_cell(0, 16'hFFFF, 16'($signed(k * 2700 - 16000)),
                                16'($signed(12000 - k * 2300)), 4, 4, 0), 0);
        drain();
        for (int ph = 0; ph < 5; ph++) begin
            stall_mode = ph % 3;
            write_reg(REG_OCC_THR, occ_set[ph % 4]);
            write_reg(REG_DIST_THR, dist_set[(ph + 1) % 4]);
            for (int n = 0; n < 250; n++) begin
                if (n % 60 == 59) stall_mode = (stall_mode + 1) % 3;
                send_cell(rand_cell(), $urandom_range(0, 5) == 0);
            end
            drain();
        end
        if (fail_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule

>>> occupancy_cell_velocity_colorizer_core.f
rtl/core/ocv_pkg.sv
rtl/core/ocv_dist.sv
rtl/core/ocv_cell.sv
rtl/core/occupancy_cell_velocity_colorizer_core.sv
dv/ocv_checker.sv
dv/tb.sv
